// ===== hw/rtl/orq_pkg.sv =====
// Shared constants, types and helpers for the overwrite ring queue with mean.
// Used by orq_ram, orq_mean and overwrite_ring_queue_with_mean.
package orq_pkg;

    localparam int QUEUE_SLOTS = 6;
    localparam int IDX_W       = $clog2(QUEUE_SLOTS);
    localparam int TAG_W       = 16;
    localparam int YEAR_W      = 12;
    // The entry count never exceeds QUEUE_SLOTS-1, so it fits in IDX_W bits.
    localparam int CNT_W       = IDX_W;
    localparam int SUM_W       = YEAR_W + CNT_W;
    localparam int STEP_W      = $clog2(YEAR_W + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [TAG_W-1:0]  t_tag;
    typedef logic [YEAR_W-1:0] t_year;

    typedef struct packed {
        t_tag  tag;
        t_year year;
    } t_entry;

    // Requests from the sequencer to the shared accumulate/divide unit.
    typedef struct packed {
        logic  clear;
        logic  acc_en;
        t_year acc_year;
        logic  div_start;
    } t_mean_ctl;

    typedef struct packed {
        logic  busy;
        t_year mean;
    } t_mean_sts;

    function automatic t_idx ring_next(input t_idx idx);
        t_idx nxt;
        if (idx == t_idx'(QUEUE_SLOTS - 1)) begin
            nxt = '0;
        end else begin
            nxt = idx + 1'b1;
        end
        return nxt;
    endfunction

endpackage

// ===== hw/rtl/orq_ram.sv =====
// Slot storage of the ring: one write port and one registered read port.
// Depends on orq_pkg for the entry type and the slot count.
module orq_ram (
    input  logic            i_clk,
    input  logic            i_we,
    input  orq_pkg::t_idx   i_waddr,
    input  orq_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  orq_pkg::t_idx   i_raddr,
    output orq_pkg::t_entry o_rdata
);
    import orq_pkg::*;

    t_entry r_mem [QUEUE_SLOTS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/orq_mean.sv =====
// Accumulates stored years and divides the sum by the entry count, one
// quotient bit per cycle. Depends on orq_pkg for widths and control structs.
module orq_mean (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  orq_pkg::t_mean_ctl   i_ctl,
    output orq_pkg::t_mean_sts   o_sts
);
    import orq_pkg::*;

    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_rem;
    t_year             r_quo;
    logic [STEP_W-1:0] r_step;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    // Remainder stays below the count, so the shifted trial is below twice it.
    assign trial = {r_rem, r_quo[YEAR_W-1]};
    assign diff  = trial - {1'b0, r_cnt};
    assign fits  = (trial >= {1'b0, r_cnt});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_ctl.div_start) begin
            r_step <= STEP_W'(YEAR_W);
        end else if (r_step != '0) begin
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_ctl.acc_en) begin
            r_sum <= r_sum + SUM_W'(i_ctl.acc_year);
            r_cnt <= r_cnt + 1'b1;
        end

        if (i_ctl.div_start) begin
            // The mean fits in YEAR_W bits, so the upper sum bits are below the count.
            r_rem <= r_sum[SUM_W-1:YEAR_W];
            r_quo <= r_sum[YEAR_W-1:0];
        end else if (r_step != '0) begin
            r_rem <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_quo <= {r_quo[YEAR_W-2:0], fits};
        end
    end

    assign o_sts.busy = (r_step != '0);
    assign o_sts.mean = r_quo;

endmodule

// ===== hw/rtl/overwrite_ring_queue_with_mean.sv =====
// Top level of the overwrite-oldest ring queue that reports the mean year.
// Depends on orq_pkg, orq_ram and orq_mean.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  request  | i_valid / o_ready  | i_operation, i_record_tag, i_birth_year
//  result   | o_valid / i_ready  | o_removed_tag, o_removed_year, o_was_empty,
//           |                    | o_evicted, o_mean_year, o_mean_valid
//
// An insert writes its entry, then the sequencer walks the ring through the
// memory's single read port to sum the stored years, and then the shared
// divider computes the mean quotient bit by bit.
// A remove reads the oldest slot, or goes straight to the result when the queue is empty.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
// A finished result waits in the output register while the next request is taken.
module overwrite_ring_queue_with_mean (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_operation,
    input  orq_pkg::t_tag       i_record_tag,
    input  orq_pkg::t_year      i_birth_year,
    output logic                o_valid,
    input  logic                i_ready,
    output orq_pkg::t_tag       o_removed_tag,
    output orq_pkg::t_year      o_removed_year,
    output logic                o_was_empty,
    output logic                o_evicted,
    output orq_pkg::t_year      o_mean_year,
    output logic                o_mean_valid
);
    import orq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_POP,
        ST_OUT
    } t_state;

    t_state r_state, n_state;
    t_idx   r_head, n_head;
    t_idx   r_tail, n_tail;
    t_idx   r_ptr, n_ptr;
    logic   r_pend, n_pend;
    t_tag   r_res_tag, n_res_tag;
    t_year  r_res_year, n_res_year;
    logic   r_res_empty, n_res_empty;
    logic   r_res_evict, n_res_evict;
    logic   r_res_mv, n_res_mv;
    logic   r_out_valid, n_out_valid;
    t_tag   r_o_tag, n_o_tag;
    t_year  r_o_year, n_o_year;
    logic   r_o_empty, n_o_empty;
    logic   r_o_evict, n_o_evict;
    t_year  r_o_mean, n_o_mean;
    logic   r_o_mv, n_o_mv;

    logic      accept;
    logic      mem_we;
    logic      mem_re;
    t_idx      mem_raddr;
    t_entry    mem_wdata;
    t_entry    mem_rdata;
    t_mean_ctl mean_ctl;
    t_mean_sts mean_sts;

    assign accept    = i_valid && o_ready;
    assign mem_wdata = '{tag: i_record_tag, year: i_birth_year};

    orq_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_tail),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    orq_mean u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mean_ctl),
        .o_sts   (mean_sts)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_ptr       = r_ptr;
        n_pend      = r_pend;
        n_res_tag   = r_res_tag;
        n_res_year  = r_res_year;
        n_res_empty = r_res_empty;
        n_res_evict = r_res_evict;
        n_res_mv    = r_res_mv;
        n_out_valid = r_out_valid && !i_ready;
        n_o_tag     = r_o_tag;
        n_o_year    = r_o_year;
        n_o_empty   = r_o_empty;
        n_o_evict   = r_o_evict;
        n_o_mean    = r_o_mean;
        n_o_mv      = r_o_mv;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = r_head;
        mean_ctl    = '0;
        mean_ctl.acc_year = mem_rdata.year;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res_tag  = '0;
                    n_res_year = '0;
                    if (i_operation == OP_INSERT) begin
                        mem_we         = 1'b1;
                        mean_ctl.clear = 1'b1;
                        n_tail         = ring_next(r_tail);
                        n_res_empty    = 1'b0;
                        n_res_mv       = 1'b1;
                        n_pend         = 1'b0;
                        // A full ring drops its oldest entry before the append.
                        if (ring_next(r_tail) == r_head) begin
                            n_head      = ring_next(r_head);
                            n_res_evict = 1'b1;
                        end else begin
                            n_res_evict = 1'b0;
                        end
                        n_ptr   = (ring_next(r_tail) == r_head) ? ring_next(r_head) : r_head;
                        n_state = ST_SUM;
                    end else begin
                        n_res_evict = 1'b0;
                        n_res_mv    = 1'b0;
                        if (r_head == r_tail) begin
                            n_res_empty = 1'b1;
                            n_state     = ST_OUT;
                        end else begin
                            n_res_empty = 1'b0;
                            mem_re      = 1'b1;
                            n_head      = ring_next(r_head);
                            n_state     = ST_POP;
                        end
                    end
                end
            end
            ST_SUM: begin
                // Each read is issued in the cycle before the accumulate it feeds.
                mean_ctl.acc_en = r_pend;
                if (r_ptr != r_tail) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr;
                    n_ptr     = ring_next(r_ptr);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = ST_DIV_GO;
                    end
                end
            end
            ST_DIV_GO: begin
                mean_ctl.div_start = 1'b1;
                n_state            = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!mean_sts.busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_POP: begin
                n_res_tag  = mem_rdata.tag;
                n_res_year = mem_rdata.year;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_o_tag     = r_res_tag;
                    n_o_year    = r_res_year;
                    n_o_empty   = r_res_empty;
                    n_o_evict   = r_res_evict;
                    n_o_mean    = r_res_mv ? mean_sts.mean : '0;
                    n_o_mv      = r_res_mv;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_ptr       <= n_ptr;
        r_res_tag   <= n_res_tag;
        r_res_year  <= n_res_year;
        r_res_empty <= n_res_empty;
        r_res_evict <= n_res_evict;
        r_res_mv    <= n_res_mv;
        r_o_tag     <= n_o_tag;
        r_o_year    <= n_o_year;
        r_o_empty   <= n_o_empty;
        r_o_evict   <= n_o_evict;
        r_o_mean    <= n_o_mean;
        r_o_mv      <= n_o_mv;
    end

    assign o_ready        = (r_state == ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_removed_tag  = r_o_tag;
    assign o_removed_year = r_o_year;
    assign o_was_empty    = r_o_empty;
    assign o_evicted      = r_o_evict;
    assign o_mean_year    = r_o_mean;
    assign o_mean_valid   = r_o_mv;

    // The pointers never leave the ring.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head < t_idx'(QUEUE_SLOTS)) && (r_tail < t_idx'(QUEUE_SLOTS)))
        else $error("ring pointer out of range");

    // The divider is idle whenever a new request can be taken.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !mean_sts.busy)
        else $error("divider busy while accepting a request");

    // After an accepted insert the queue is never empty.
    a_insert_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation == OP_INSERT)) |=> (r_head != r_tail))
        else $error("queue empty after insert");

    // A result never carries both an empty remove and an insert mean, and only an insert flags an eviction.
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_mean_valid && o_was_empty) && !(!o_mean_valid && o_evicted))
        else $error("inconsistent result flags");

endmodule

// ===== test/overwrite_ring_queue_with_mean_tb.sv =====
// Self-checking testbench for overwrite_ring_queue_with_mean: it drives insert and remove
// requests, predicts every reply in a scoreboard class and compares replies field by field.
// Depends on orq_pkg and the overwrite_ring_queue_with_mean RTL.
module overwrite_ring_queue_with_mean_tb;
    import orq_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        t_tag  removed_tag;
        t_year removed_year;
        logic  was_empty;
        logic  evicted;
        t_year mean_year;
        logic  mean_valid;
    } t_queue_reply;

    class t_queue_mean_scoreboard;
        t_tag         ring_tag[QUEUE_SLOTS];
        t_year        ring_year[QUEUE_SLOTS];
        int unsigned  oldest;
        int unsigned  free_slot;
        t_queue_reply awaited_replies[$];
        int           errors;

        function new();
            oldest    = 0;
            free_slot = 0;
            errors    = 0;
        endfunction

        function int unsigned step_index(int unsigned idx);
            return (idx + 1) % QUEUE_SLOTS;
        endfunction

        // Applies one accepted request to the shadow ring and queues the reply it must produce.
        function void take_request(logic op, t_tag tag, t_year year);
            t_queue_reply reply;
            int unsigned  idx;
            int unsigned  year_sum;
            int unsigned  entries;
            reply    = '0;
            year_sum = 0;
            entries  = 0;
            if (op == OP_INSERT) begin
                if (step_index(free_slot) == oldest) begin
                    oldest        = step_index(oldest);
                    reply.evicted = 1'b1;
                end
                ring_tag[free_slot]  = tag;
                ring_year[free_slot] = year;
                free_slot            = step_index(free_slot);
                for (idx = oldest; idx != free_slot; idx = step_index(idx)) begin
                    year_sum += ring_year[idx];
                    entries++;
                end
                reply.mean_year  = t_year'(year_sum / entries);
                reply.mean_valid = 1'b1;
            end else if (oldest == free_slot) begin
                reply.was_empty = 1'b1;
            end else begin
                reply.removed_tag  = ring_tag[oldest];
                reply.removed_year = ring_year[oldest];
                oldest             = step_index(oldest);
            end
            awaited_replies.push_back(reply);
        endfunction

        function void flag_field(string field, logic [15:0] want, logic [15:0] got);
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors++;
        endfunction

        function void check_reply(t_queue_reply got);
            t_queue_reply want;
            if (awaited_replies.size() == 0) begin
                $display("%0t: unexpected reply, expected nothing, actual %h", $time, got);
                errors++;
                return;
            end
            want = awaited_replies.pop_front();
            if (got.removed_tag !== want.removed_tag)
                flag_field("removed_tag", want.removed_tag, got.removed_tag);
            if (got.removed_year !== want.removed_year)
                flag_field("removed_year", want.removed_year, got.removed_year);
            if (got.was_empty !== want.was_empty)
                flag_field("was_empty", want.was_empty, got.was_empty);
            if (got.evicted !== want.evicted)
                flag_field("evicted", want.evicted, got.evicted);
            if (got.mean_year !== want.mean_year)
                flag_field("mean_year", want.mean_year, got.mean_year);
            if (got.mean_valid !== want.mean_valid)
                flag_field("mean_valid", want.mean_valid, got.mean_valid);
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_valid;
    logic         o_ready;
    logic         i_operation;
    t_tag         i_record_tag;
    t_year        i_birth_year;
    logic         o_valid;
    logic         i_ready;
    t_tag         o_removed_tag;
    t_year        o_removed_year;
    logic         o_was_empty;
    logic         o_evicted;
    t_year        o_mean_year;
    logic         o_mean_valid;

    int           send_idle_pct;
    int           recv_idle_pct;
    int           stall_cycles;
    t_queue_reply observed_reply;
    t_queue_mean_scoreboard sb = new();

    overwrite_ring_queue_with_mean DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_record_tag   (i_record_tag),
        .i_birth_year   (i_birth_year),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_removed_tag  (o_removed_tag),
        .o_removed_year (o_removed_year),
        .o_was_empty    (o_was_empty),
        .o_evicted      (o_evicted),
        .o_mean_year    (o_mean_year),
        .o_mean_valid   (o_mean_valid)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Both channels are sampled here with the values they held before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                observed_reply.removed_tag  = o_removed_tag;
                observed_reply.removed_year = o_removed_year;
                observed_reply.was_empty    = o_was_empty;
                observed_reply.evicted      = o_evicted;
                observed_reply.mean_year    = o_mean_year;
                observed_reply.mean_valid   = o_mean_valid;
                sb.check_reply(observed_reply);
            end
            if (i_valid && o_ready) begin
                sb.take_request(i_operation, i_record_tag, i_birth_year);
            end
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Holds the request until it is accepted; an idle gap may come first.
    task automatic send_request(input logic op, input t_tag tag, input t_year year);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_record_tag <= tag;
        i_birth_year <= year;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited_replies.size() != 0) @(posedge i_clk);
    endtask

    // Random traffic; the insert share drifts so the queue swings between empty and full.
    task automatic run_random(input int count);
        int    insert_pct;
        logic  op;
        t_year year;
        insert_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 16 == 0) insert_pct = $urandom_range(20, 85);
            op   = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
            year = ($urandom_range(9) == 0) ? '1 : t_year'($urandom);
            send_request(op, t_tag'($urandom), year);
        end
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_ready       = 1'b0;
        i_operation   = OP_INSERT;
        i_record_tag  = '0;
        i_birth_year  = '0;
        stall_cycles  = 0;
        send_idle_pct = 27;
        recv_idle_pct = 78;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Remove from an empty queue, fill past capacity with extreme values so
        // that the oldest entries are overwritten, then empty it again.
        send_request(OP_REMOVE, '1, '1);
        send_request(OP_INSERT, '1, '1);
        send_request(OP_INSERT, '0, '0);
        send_request(OP_INSERT, 16'h5A5A, 12'hA5A);
        send_request(OP_INSERT, 16'hA5A5, 12'h5A5);
        send_request(OP_INSERT, '1, '1);
        send_request(OP_INSERT, 16'h8001, '1);
        send_request(OP_INSERT, 16'h7FFE, '1);
        send_request(OP_INSERT, '1, '1);
        send_request(OP_INSERT, '1, '1);
        repeat (QUEUE_SLOTS) send_request(OP_REMOVE, '0, '0);
        send_request(OP_INSERT, 16'h0001, 12'h001);
        send_request(OP_REMOVE, '1, '1);
        send_request(OP_INSERT, 16'h1234, 12'h002);
        send_request(OP_INSERT, 16'h4321, 12'h003);
        send_request(OP_REMOVE, '0, '0);
        wait_for_drain();

        run_random(135);
        wait_for_drain();
        send_idle_pct <= 78;
        recv_idle_pct <= 27;
        @(posedge i_clk);
        run_random(135);
        wait_for_drain();
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        @(posedge i_clk);
        run_random(135);
        wait_for_drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited_replies.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/orq_pkg.sv
hw/rtl/orq_ram.sv
hw/rtl/orq_mean.sv
hw/rtl/overwrite_ring_queue_with_mean.sv
test/overwrite_ring_queue_with_mean_tb.sv
